>>> src/swhr_pkg.sv
// ----------------------------------------------------------------------------
// Single-wire humidity sensor reader package
// Shared types, register defaults and protocol timing constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swhr_pkg;

   // Fixed field widths
   localparam int unsigned TimerW  = 16;
   localparam int unsigned ThreshW = 7;
   localparam int unsigned AttW    = 3;
   localparam int unsigned HoldW   = 10;
   localparam int unsigned StatusW = 2;
   localparam int unsigned DataW   = 40;
   localparam int unsigned CsrIdxW = 2;
   localparam int unsigned CsrDataW = 16;
   localparam int unsigned ReqDataW = 8;
   localparam int unsigned RspDataW = 48;

   localparam int unsigned FRAME_BITS_DEFAULT = 40;

   // Register indexes
   localparam logic [CsrIdxW-1:0] CSR_START_LOW = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_ONE_THRESH = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_MAX_ATTEMPTS = 2'd2;
   localparam logic [CsrIdxW-1:0] CSR_END_HOLD = 2'd3;

   // Register reset values
   localparam logic [TimerW-1:0]  START_LOW_RESET  = 16'd19000;
   localparam logic [ThreshW-1:0] ONE_THRESH_RESET = 7'd40;
   localparam logic [AttW-1:0]    MAX_ATT_RESET    = 3'd5;
   localparam logic [HoldW-1:0]   END_HOLD_RESET   = 10'd200;

   // Handshake and bit timing in microsecond ticks
   localparam logic [TimerW-1:0] RESP_LOW_MAX   = 16'd40;
   localparam logic [TimerW-1:0] RESP_HIGH_SKIP = 16'd40;
   localparam logic [TimerW-1:0] RESP_HIGH_MAX  = 16'd85;
   localparam logic [TimerW-1:0] RESP_END_SKIP  = 16'd30;
   localparam logic [TimerW-1:0] RESP_END_MAX   = 16'd100;
   localparam logic [TimerW-1:0] BIT_WAIT_MAX   = 16'd50;
   localparam logic [TimerW-1:0] BIT_HIGH_MAX   = 16'd70;

   // Operation codes
   localparam logic OP_TICK    = 1'b0;
   localparam logic OP_REQUEST = 1'b1;

   // Status codes
   localparam logic [StatusW-1:0] ST_OK          = 2'd0;
   localparam logic [StatusW-1:0] ST_NO_RESP_LOW = 2'd1;
   localparam logic [StatusW-1:0] ST_NO_RESP_HIGH = 2'd2;
   localparam logic [StatusW-1:0] ST_NO_END_LOW  = 2'd3;

   typedef enum logic [7:0] {
      PH_IDLE      = 8'b0000_0001,
      PH_START_LOW = 8'b0000_0010,
      PH_RESP_LOW  = 8'b0000_0100,
      PH_RESP_HIGH = 8'b0000_1000,
      PH_RESP_END  = 8'b0001_0000,
      PH_BIT_WAIT  = 8'b0010_0000,
      PH_BIT_HIGH  = 8'b0100_0000,
      PH_END_HOLD  = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [TimerW-1:0]  start_low;
      logic [ThreshW-1:0] one_thresh;
      logic [AttW-1:0]    max_attempts;
      logic [HoldW-1:0]   end_hold;
   } cfg_type;

   typedef struct packed {
      logic [DataW-1:0]   frame_data;
      logic [StatusW-1:0] status;
      logic               done_res;
      logic               busy_res;
      logic               drive_low;
   } step_type;

endpackage

`default_nettype wire

>>> src/swhr_csr.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the four timing and retry registers written through the CSR port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swhr_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wen,
   input  wire logic [swhr_pkg::CsrIdxW-1:0]      csr_index,
   input  wire logic [swhr_pkg::CsrDataW-1:0]     csr_wdata,
   output swhr_pkg::cfg_type                      cfg
);

   swhr_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            swhr_pkg::CSR_START_LOW: begin
               cfg_in.start_low = csr_wdata[swhr_pkg::TimerW-1:0];
            end
            swhr_pkg::CSR_ONE_THRESH: begin
               cfg_in.one_thresh = csr_wdata[swhr_pkg::ThreshW-1:0];
            end
            swhr_pkg::CSR_MAX_ATTEMPTS: begin
               cfg_in.max_attempts = csr_wdata[swhr_pkg::AttW-1:0];
            end
            swhr_pkg::CSR_END_HOLD: begin
               cfg_in.end_hold = csr_wdata[swhr_pkg::HoldW-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_low    <= swhr_pkg::START_LOW_RESET;
         cfg_ff.one_thresh   <= swhr_pkg::ONE_THRESH_RESET;
         cfg_ff.max_attempts <= swhr_pkg::MAX_ATT_RESET;
         cfg_ff.end_hold     <= swhr_pkg::END_HOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> src/swhr_core.sv
// ----------------------------------------------------------------------------
// Sensor protocol sequencer
// Phase, timer, bit counter and shift register, advanced once per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swhr_core #(
   parameter int unsigned FRAME_BITS = swhr_pkg::FRAME_BITS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step_en,
   input  wire logic               op,
   input  wire logic               line_level,
   input  wire swhr_pkg::cfg_type  cfg,
   output swhr_pkg::step_type      step
);

   localparam int unsigned CntW = $clog2(FRAME_BITS + 1);
   localparam logic [CntW-1:0] LastCnt = CntW'(FRAME_BITS);

   swhr_pkg::phase_type                 phase_ff, phase_in;
   logic [swhr_pkg::TimerW-1:0]         timer_ff, timer_in;
   logic [CntW-1:0]                     bit_cnt_ff, bit_cnt_in;
   logic [swhr_pkg::DataW-1:0]          shift_ff, shift_in;
   logic [swhr_pkg::AttW-1:0]           att_ff, att_in;
   logic [swhr_pkg::StatusW-1:0]        status_ff, status_in;

   logic [swhr_pkg::TimerW-1:0]         timer_inc;
   logic [swhr_pkg::AttW-1:0]           att_next;
   logic [CntW-1:0]                     cnt_next;
   logic [swhr_pkg::TimerW-1:0]         thresh_ext;
   logic                                done;
   logic                                fail_hit;

   assign timer_inc  = (timer_ff == '1) ? timer_ff : timer_ff + 1'b1;
   assign att_next   = att_ff + 1'b1;
   assign cnt_next   = bit_cnt_ff + 1'b1;
   assign thresh_ext = swhr_pkg::TimerW'(cfg.one_thresh);

   // A handshake check has timed out on this tick.
   always_comb begin
      fail_hit = 1'b0;
      if (op == swhr_pkg::OP_TICK) begin
         case (phase_ff)
            swhr_pkg::PH_RESP_LOW: begin
               fail_hit = line_level && timer_inc >= swhr_pkg::RESP_LOW_MAX;
            end
            swhr_pkg::PH_RESP_HIGH: begin
               fail_hit = !(timer_inc >= swhr_pkg::RESP_HIGH_SKIP && line_level) &&
                          timer_inc >= swhr_pkg::RESP_HIGH_MAX;
            end
            swhr_pkg::PH_RESP_END: begin
               fail_hit = !(timer_inc >= swhr_pkg::RESP_END_SKIP && !line_level) &&
                          timer_inc >= swhr_pkg::RESP_END_MAX;
            end
            default: begin
               fail_hit = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      timer_in   = timer_ff;
      bit_cnt_in = bit_cnt_ff;
      shift_in   = shift_ff;
      att_in     = att_ff;
      status_in  = status_ff;
      done       = 1'b0;

      if (op == swhr_pkg::OP_REQUEST) begin
         // A request while a reading runs is dropped.
         if (phase_ff == swhr_pkg::PH_IDLE) begin
            phase_in   = swhr_pkg::PH_START_LOW;
            timer_in   = '0;
            bit_cnt_in = '0;
            shift_in   = '0;
            att_in     = '0;
         end
      end else begin
         case (phase_ff)
            swhr_pkg::PH_IDLE: begin
               phase_in = swhr_pkg::PH_IDLE;
            end
            swhr_pkg::PH_START_LOW: begin
               timer_in = timer_inc;
               if (timer_inc >= cfg.start_low) begin
                  phase_in = swhr_pkg::PH_RESP_LOW;
                  timer_in = '0;
               end
            end
            swhr_pkg::PH_RESP_LOW: begin
               if (!line_level) begin
                  phase_in = swhr_pkg::PH_RESP_HIGH;
                  timer_in = '0;
               end else begin
                  timer_in = timer_inc;
                  if (timer_inc >= swhr_pkg::RESP_LOW_MAX) begin
                     status_in = swhr_pkg::ST_NO_RESP_LOW;
                  end
               end
            end
            swhr_pkg::PH_RESP_HIGH: begin
               timer_in = timer_inc;
               if (timer_inc >= swhr_pkg::RESP_HIGH_SKIP && line_level) begin
                  phase_in = swhr_pkg::PH_RESP_END;
                  timer_in = '0;
               end else if (timer_inc >= swhr_pkg::RESP_HIGH_MAX) begin
                  status_in = swhr_pkg::ST_NO_RESP_HIGH;
               end
            end
            swhr_pkg::PH_RESP_END: begin
               timer_in = timer_inc;
               if (timer_inc >= swhr_pkg::RESP_END_SKIP && !line_level) begin
                  phase_in = swhr_pkg::PH_BIT_WAIT;
                  timer_in = '0;
               end else if (timer_inc >= swhr_pkg::RESP_END_MAX) begin
                  status_in = swhr_pkg::ST_NO_END_LOW;
               end
            end
            swhr_pkg::PH_BIT_WAIT: begin
               if (line_level) begin
                  phase_in = swhr_pkg::PH_BIT_HIGH;
                  timer_in = swhr_pkg::TimerW'(1);
               end else begin
                  timer_in = timer_inc;
                  if (timer_inc >= swhr_pkg::BIT_WAIT_MAX) begin
                     // No rising edge in time: the bit reads as zero.
                     shift_in   = {shift_ff[swhr_pkg::DataW-2:0], 1'b0};
                     timer_in   = '0;
                     bit_cnt_in = cnt_next;
                     phase_in   = (cnt_next >= LastCnt) ? swhr_pkg::PH_END_HOLD
                                                        : swhr_pkg::PH_BIT_WAIT;
                  end
               end
            end
            swhr_pkg::PH_BIT_HIGH: begin
               if (line_level) begin
                  timer_in = timer_inc;
                  if (timer_inc >= swhr_pkg::BIT_HIGH_MAX) begin
                     shift_in   = {shift_ff[swhr_pkg::DataW-2:0],
                                   timer_inc >= thresh_ext};
                     timer_in   = '0;
                     bit_cnt_in = cnt_next;
                     phase_in   = (cnt_next >= LastCnt) ? swhr_pkg::PH_END_HOLD
                                                        : swhr_pkg::PH_BIT_WAIT;
                  end
               end else begin
                  shift_in   = {shift_ff[swhr_pkg::DataW-2:0], timer_ff >= thresh_ext};
                  timer_in   = '0;
                  bit_cnt_in = cnt_next;
                  phase_in   = (cnt_next >= LastCnt) ? swhr_pkg::PH_END_HOLD
                                                     : swhr_pkg::PH_BIT_WAIT;
               end
            end
            swhr_pkg::PH_END_HOLD: begin
               timer_in = timer_inc;
               if (timer_inc >= swhr_pkg::TimerW'(cfg.end_hold)) begin
                  phase_in  = swhr_pkg::PH_IDLE;
                  timer_in  = '0;
                  status_in = swhr_pkg::ST_OK;
                  done      = 1'b1;
               end
            end
            default: begin
               phase_in = swhr_pkg::PH_IDLE;
            end
         endcase

         // Handshake failure: count the attempt and either retry or give up.
         if (fail_hit) begin
            att_in   = att_next;
            timer_in = '0;
            if (att_next < cfg.max_attempts) begin
               phase_in = swhr_pkg::PH_START_LOW;
            end else begin
               phase_in = swhr_pkg::PH_IDLE;
               done     = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= swhr_pkg::PH_IDLE;
         timer_ff   <= '0;
         bit_cnt_ff <= '0;
         shift_ff   <= '0;
         att_ff     <= '0;
         status_ff  <= swhr_pkg::ST_OK;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         timer_ff   <= timer_in;
         bit_cnt_ff <= bit_cnt_in;
         shift_ff   <= shift_in;
         att_ff     <= att_in;
         status_ff  <= status_in;
      end
   end

   always_comb begin
      step.drive_low  = (phase_in == swhr_pkg::PH_START_LOW);
      step.busy_res   = (phase_in != swhr_pkg::PH_IDLE);
      step.done_res   = done;
      step.status     = status_in;
      step.frame_data = shift_in;
   end

endmodule

`default_nettype wire

>>> src/swhr_out.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one result transaction until the downstream side takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swhr_out (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           load,
   input  wire swhr_pkg::step_type             step,
   input  wire logic                           rsp_tready,
   output logic                                rsp_tvalid,
   output logic [swhr_pkg::RspDataW-1:0]       rsp_tdata,
   output logic                                space
);

   logic               valid_ff, valid_in;
   swhr_pkg::step_type data_ff;

   // The register is free when empty or being drained this cycle.
   assign space    = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= step;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(swhr_pkg::RspDataW - $bits(swhr_pkg::step_type)){1'b0}}, data_ff};

endmodule

`default_nettype wire

>>> src/single_wire_humidity_sensor_reader.sv
// ----------------------------------------------------------------------------
// Single-wire humidity sensor reader
// Drives the start pulse, checks the sensor handshake and collects the frame.
// ----------------------------------------------------------------------------
// A transaction's result is registered and appears in the cycle after it is
// accepted. One transaction per cycle unless the result channel stalls; the
// sequencer updates in one pass, and the result register accepts as it drains.
// Reset is synchronous and active high: the line is released, the sequencer
// idles and the registers return to their defaults (19000, 40, 5, 200).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module single_wire_humidity_sensor_reader #(
   parameter int unsigned FRAME_BITS = swhr_pkg::FRAME_BITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Request channel.
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [swhr_pkg::ReqDataW-1:0]   req_tdata,  // [0] line_level, rest zero
   input  wire logic                            req_tuser,  // [0] op
   // Result channel.
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [0] drive_low, [1] busy_res, [2] done_res, [4:3] status,
   // [44:5] frame_data, rest zero
   output logic [swhr_pkg::RspDataW-1:0]        rsp_tdata,
   // Configuration write port.
   input  wire logic                            csr_wen,
   input  wire logic [swhr_pkg::CsrIdxW-1:0]    csr_index,
   input  wire logic [swhr_pkg::CsrDataW-1:0]   csr_wdata
);

   swhr_pkg::cfg_type  cfg;
   swhr_pkg::step_type step;
   logic               space;
   logic               accept;

   // Each request transaction is either a microsecond tick carrying the sampled
   // line, or a request to start a reading. Every transaction yields exactly one
   // result showing the sequencer state after it.
   assign req_tready = space;
   assign accept     = req_tvalid && space;

   swhr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The sequencer advances only on an accepted transaction; its next-state
   // view is captured into the result register in the same cycle.
   swhr_core #(
      .FRAME_BITS (FRAME_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (accept),
      .op         (req_tuser),
      .line_level (req_tdata[0]),
      .cfg        (cfg),
      .step       (step)
   );

   swhr_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .step       (step),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .space      (space)
   );

   // The line is only pulled low while a reading is in progress.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[1])
      else $error("drive_low reported while not busy");

   // A finished reading leaves the sequencer idle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> !rsp_tdata[1] && !rsp_tdata[0])
      else $error("done reported while still busy");

   // An empty result register never stalls the request side.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty result register");

   // Every accepted transaction produces a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted transaction produced no result");

endmodule

`default_nettype wire
